FILE: hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg - ordered list engine shared definitions
// Sizes, field widths, action/status codes and the command broadcast to cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam int CAPACITY = 16;                      // 2 .. 64
    localparam int CNT_W    = $clog2(CAPACITY + 1);    // holds 0 .. CAPACITY
    localparam int IDX_W    = $clog2(CAPACITY);        // addresses one cell

    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;

    localparam int IN_RAW_W  = ACT_W + POS_W + DATA_W;
    localparam int OUT_RAW_W = STAT_W + DATA_W + LEN_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_DUMP_FWD  = 3'd6,
        ACT_DUMP_BACK = 3'd7
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INS,
        CO_DEL,
        CO_ROTL,
        CO_ROTR
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    typedef struct packed {
        t_cell_op          op;
        logic [CNT_W-1:0]  idx;        // target position (zero based)
        logic [CNT_W-1:0]  cnt;        // element count before the operation
        logic [DATA_W-1:0] ins_value;  // value written on insert
        logic [DATA_W-1:0] wrap_value; // value entering at the wrap end on rotate
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: hw/rtl/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell - one storage cell of the list chain
// Holds one element; shifts from a neighbor on insert, delete and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_cell (
    input  wire logic                          i_clk,
    input  wire ole_pkg::t_cell_cmd            i_cmd,
    input  wire logic [ole_pkg::CNT_W-1:0]     i_index,
    input  wire logic [ole_pkg::DATA_W-1:0]    i_left,
    input  wire logic [ole_pkg::DATA_W-1:0]    i_right,
    output logic      [ole_pkg::DATA_W-1:0]    o_value
);
    import ole_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic [CNT_W:0]    w_index_p1;
    logic [CNT_W:0]    w_cnt_x;

    assign w_index_p1 = {1'b0, i_index} + {{CNT_W{1'b0}}, 1'b1};
    assign w_cnt_x    = {1'b0, i_cmd.cnt};

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CO_INS: begin
                if (i_index == i_cmd.idx) begin
                    n_value = i_cmd.ins_value;
                end else if (i_index > i_cmd.idx && i_index <= i_cmd.cnt) begin
                    n_value = i_left;
                end
            end
            CO_DEL: begin
                if (i_index >= i_cmd.idx && w_index_p1 < w_cnt_x) begin
                    n_value = i_right;
                end
            end
            CO_ROTL: begin
                if (w_index_p1 < w_cnt_x) begin
                    n_value = i_right;
                end else if (w_index_p1 == w_cnt_x) begin
                    n_value = i_cmd.wrap_value;
                end
            end
            CO_ROTR: begin
                if (i_index == '0) begin
                    n_value = i_cmd.wrap_value;
                end else if (i_index < i_cmd.cnt) begin
                    n_value = i_left;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top - bounded ordered list of signed 32-bit values
// Insert/delete at front, back or position, forward and backward dumps,
// built as a chain of element cells with a small controller.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake                    | Contents
//  --------+-----+------------------------------+-------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | action, position, value
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | status, value_out, length; tlast
//
//  Insert and delete shift the chain one place and register the single
//  result; a failed operation only registers its result. A dump of n
//  elements holds the input and makes one rotation and one result per cycle
//  while the output is free; after n rotations the list is back in order.
//  Reset (i_rst_n low, synchronous) empties the list and drops any result.
//  A stalled output holds its result and blocks both new items and the dump.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // action[2:0], position[9:3], value[41:10], zero fill above
    input  wire logic [ole_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // status[1:0], value_out[33:2], length[40:34], zero fill above
    output logic      [ole_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic                                  m_axis_tlast
);
    import ole_pkg::*;

    // input field split
    t_action           w_action;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_in_value;

    assign w_action   = t_action'(s_axis_tdata[ACT_W-1:0]);
    assign w_pos      = s_axis_tdata[ACT_W +: POS_W];
    assign w_in_value = s_axis_tdata[ACT_W+POS_W +: DATA_W];

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_dump_cnt, n_dump_cnt;
    logic              r_dump_back, n_dump_back;

    // output register
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_value_out;
    logic [LEN_W-1:0]  r_length;
    logic              r_last;

    logic              w_load;
    t_status           w_status;
    logic [DATA_W-1:0] w_value_out;
    logic              w_last;

    // cell chain
    t_cell_cmd         w_cmd;
    logic [DATA_W-1:0] w_cell [CAPACITY];
    logic [IDX_W-1:0]  w_rd_idx;
    logic [DATA_W-1:0] w_rd_value;

    logic              w_out_free;
    logic              w_accept;
    logic              w_dump_done;

    // helpers on the current count and position
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [POS_W:0]    w_pos_x;
    logic [POS_W:0]    w_cnt_x;
    logic [POS_W-1:0]  w_pos_m1;
    logic [CNT_W-1:0]  w_pos_idx;
    logic              w_empty;
    logic              w_full;
    logic              w_ins_range_bad;
    logic              w_del_range_bad;

    assign w_cnt_m1        = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
    assign w_pos_x         = {1'b0, w_pos};
    assign w_cnt_x         = (POS_W + 1)'(r_count);
    assign w_pos_m1        = w_pos - {{(POS_W-1){1'b0}}, 1'b1};
    assign w_pos_idx       = w_pos_m1[CNT_W-1:0];
    assign w_empty         = (r_count == '0);
    assign w_full          = (r_count == CNT_W'(CAPACITY));
    assign w_ins_range_bad = (w_pos_x < (POS_W + 1)'(2)) ||
                             (w_pos_x > w_cnt_x + (POS_W + 1)'(1));
    assign w_del_range_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x);

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_dump_done = w_out_free && (r_dump_cnt == w_cnt_m1);

    // single read port into the chain: delete target in idle, tail in dump
    always_comb begin
        w_rd_idx = w_cnt_m1[IDX_W-1:0];
        if (r_state == ST_IDLE) begin
            case (w_action)
                ACT_DEL_FRONT: w_rd_idx = '0;
                ACT_DEL_AT:    w_rd_idx = w_pos_idx[IDX_W-1:0];
                default:       w_rd_idx = w_cnt_m1[IDX_W-1:0];
            endcase
        end
    end

    assign w_rd_value = w_cell[w_rd_idx];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_empty &&
                    (w_action == ACT_DUMP_FWD || w_action == ACT_DUMP_BACK)) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (w_dump_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb begin
        s_axis_tready     = 1'b0;
        w_cmd.op          = CO_HOLD;
        w_cmd.idx         = '0;
        w_cmd.cnt         = r_count;
        w_cmd.ins_value   = w_in_value;
        w_cmd.wrap_value  = w_cell[0];
        w_load            = 1'b0;
        w_status          = STAT_OK;
        w_value_out       = '0;
        w_last            = 1'b1;
        n_count           = r_count;
        n_dump_cnt        = r_dump_cnt;
        n_dump_back       = r_dump_back;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
                if (w_accept) begin
                    w_load = 1'b1;
                    case (w_action)
                        ACT_INS_FRONT, ACT_INS_BACK: begin
                            if (w_full) begin
                                w_status = STAT_FULL;
                            end else begin
                                w_cmd.op  = CO_INS;
                                w_cmd.idx = (w_action == ACT_INS_FRONT) ? '0 : r_count;
                                n_count   = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        ACT_INS_AT: begin
                            if (w_empty) begin
                                w_status = STAT_EMPTY;
                            end else if (w_ins_range_bad) begin
                                w_status = STAT_RANGE;
                            end else if (w_full) begin
                                w_status = STAT_FULL;
                            end else begin
                                w_cmd.op  = CO_INS;
                                w_cmd.idx = w_pos_idx;
                                n_count   = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
                            if (w_empty) begin
                                w_status = STAT_EMPTY;
                            end else if (w_action == ACT_DEL_AT && w_del_range_bad) begin
                                w_status = STAT_RANGE;
                            end else begin
                                w_cmd.op    = CO_DEL;
                                w_cmd.idx   = CNT_W'(w_rd_idx);
                                w_value_out = w_rd_value;
                                n_count     = w_cnt_m1;
                            end
                        end
                        default: begin
                            // dumps: an empty list answers at once
                            if (w_empty) begin
                                w_status = STAT_EMPTY;
                            end else begin
                                w_load      = 1'b0;
                                n_dump_cnt  = '0;
                                n_dump_back = (w_action == ACT_DUMP_BACK);
                            end
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_last      = (r_dump_cnt == w_cnt_m1);
                    n_dump_cnt  = r_dump_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
                    if (r_dump_back) begin
                        w_cmd.op         = CO_ROTR;
                        w_cmd.wrap_value = w_rd_value;
                        w_value_out      = w_rd_value;
                    end else begin
                        w_cmd.op         = CO_ROTL;
                        w_cmd.wrap_value = w_cell[0];
                        w_value_out      = w_cell[0];
                    end
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_lastc
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (CNT_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dump_cnt  <= '0;
            r_dump_back <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_cnt  <= n_dump_cnt;
            r_dump_back <= n_dump_back;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= w_status;
            r_value_out <= w_value_out;
            r_length    <= LEN_W'(n_count);
            r_last      <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_RAW_W){1'b0}},
                            r_length, r_value_out, r_status};

endmodule

`default_nettype wire
